FILE: design/bbc_pkg.sv
`timescale 1ns / 1ps
package bbc_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 17;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	localparam logic [7:0]  DEV_ONES = 8'hFF;
	localparam logic [31:0] BLK_ONES = 32'hFFFF_FFFF;

	// request kinds as they arrive on the input word
	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_WRITE   = 3'd1;
	localparam logic [2:0] KIND_RELEASE = 3'd2;
	localparam logic [2:0] KIND_INVAL   = 3'd3;
	localparam logic [2:0] KIND_SYNC    = 3'd4;

	// fill outcomes; anything else counts as a read error
	localparam logic [1:0] FS_OK    = 2'd0;
	localparam logic [1:0] FS_NODEV = 2'd1;

	typedef enum logic [2:0] {
		CODE_GRANTED   = 3'd0,
		CODE_WRITEBACK = 3'd1,
		CODE_FILL      = 3'd2,
		CODE_FAILED    = 3'd3,
		CODE_DONE      = 3'd4
	} code_t;

	typedef enum logic [2:0] {
		OP_READ, OP_WRITE, OP_RELEASE, OP_INVAL, OP_SYNC, OP_BAD
	} op_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [3:0]  slot_index;
		logic [1:0]  fill_status;
	} req_t;

	typedef struct packed {
		code_t       code;
		logic [3:0]  slot;
		logic        hit;
		logic [7:0]  out_device;
		logic [31:0] out_block;
		logic        last;
	} rsp_t;

	// classified request held in the queue between front and back
	typedef struct packed {
		op_t         op;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [3:0]  slot_index;
		logic [1:0]  fill_status;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

FILE: design/bbc_if.sv
`timescale 1ns / 1ps
interface bbc_req_if;
	logic          valid;
	logic          ready;
	bbc_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bbc_rsp_if;
	logic          valid;
	logic          ready;
	bbc_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// Tag and LRU policy engine of a fully associative write-back block cache.
// Requests enter a two-word queue and are carried out one at a time. A hit,
// release, invalidate or unknown kind passes through the idle, lookup and
// execute states; a miss adds the fill and finish states, whether or not the
// victim is dirty. A sync walks the recency order one rank per cycle while the
// result side accepts its write-back words, then emits the done word. Each
// result word passes through a single output register.
module block_buffer_cache_lru #(
	parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bbc_req_if.sink   req,
	bbc_rsp_if.source rsp
);

	bbc_pkg::head_t head;
	logic           pop;

	bbc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	bbc_engine #(
		.SLOTS (SLOTS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

FILE: design/bbc_front.sv
`timescale 1ns / 1ps
module bbc_front (
	input  logic           clk,
	input  logic           arst_n,
	bbc_req_if.sink        req,
	input  logic           pop,
	output bbc_pkg::head_t head
);

	bbc_pkg::entry_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	bbc_pkg::entry_t cls;
	logic            push;
	logic            take;

	// classify the incoming word
	always_comb begin
		cls.device       = req.data.device;
		cls.block_number = req.data.block_number;
		cls.slot_index   = req.data.slot_index;
		cls.fill_status  = req.data.fill_status;
		case (req.data.kind)
			bbc_pkg::KIND_READ:    cls.op = bbc_pkg::OP_READ;
			bbc_pkg::KIND_WRITE:   cls.op = bbc_pkg::OP_WRITE;
			bbc_pkg::KIND_RELEASE: cls.op = bbc_pkg::OP_RELEASE;
			bbc_pkg::KIND_INVAL:   cls.op = bbc_pkg::OP_INVAL;
			bbc_pkg::KIND_SYNC:    cls.op = bbc_pkg::OP_SYNC;
			default:               cls.op = bbc_pkg::OP_BAD;
		endcase
	end

	assign req.ready  = (count_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign take       = pop && (count_q != 2'd0);
	assign head.valid = (count_q != 2'd0);
	assign head.entry = fifo_q[rd_ptr_q];

	// hold the payload of queued words
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(take);
		end
	end

endmodule

FILE: design/bbc_engine.sv
`timescale 1ns / 1ps
module bbc_engine #(
	parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bbc_pkg::head_t head,
	output logic           pop,
	bbc_rsp_if.source      rsp
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = $clog2(SLOTS + 1);
	localparam logic [SW-1:0] LAST_RANK = SW'(SLOTS - 1);
	localparam logic [RW-1:0] RANK_END = RW'(SLOTS);
	localparam logic [bbc_pkg::CNT_W-1:0] WB_MAX = bbc_pkg::CNT_W'(bbc_pkg::MAX_RESULTS - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOOK = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_FILL = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_SYNC = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [SLOTS-1:0] valid_q, dirty_q, busy_q;
	logic [7:0]       tdev_q [SLOTS];
	logic [31:0]      tblk_q [SLOTS];
	logic [SW-1:0]    rank_q [SLOTS];

	bbc_pkg::entry_t  req_q;
	logic             hit_q;
	logic [SW-1:0]    mslot_q;
	logic [SW-1:0]    vict_q;
	logic [RW-1:0]    rnk_q;
	logic [bbc_pkg::CNT_W-1:0] cnt_q;

	bbc_pkg::rsp_t    oreg_q;
	logic             oval_q;

	logic [SLOTS-1:0] match;
	logic             any_match;
	logic [SW-1:0]    midx, vidx, sidx;
	logic             can_emit, emit;
	bbc_pkg::rsp_t    edata;
	logic             do_hit, do_clear, do_fin, do_rel, do_inv, do_syncwb, adv;
	logic             mru_en;
	logic [SW-1:0]    mru_slot;
	logic [SW-1:0]    mru_old;
	logic             is_wr;

	// widen a slot number to the 4-bit result field
	function automatic logic [3:0] slot4(input logic [SW-1:0] s);
		logic [SW+3:0] w;
		w = {4'b0, s};
		return w[3:0];
	endfunction

	// search tags, find the victim and the slot at the current sync rank
	always_comb begin
		midx = '0;
		vidx = '0;
		sidx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (tdev_q[i] == req_q.device)
				&& (tblk_q[i] == req_q.block_number);
			if (match[i]) begin
				midx = midx | SW'(i);
			end
			if (rank_q[i] == LAST_RANK) begin
				vidx = vidx | SW'(i);
			end
			if (rank_q[i] == rnk_q[SW-1:0]) begin
				sidx = sidx | SW'(i);
			end
		end
		any_match = |match;
	end

	assign can_emit = !oval_q || rsp.ready;
	assign is_wr    = (req_q.op == bbc_pkg::OP_WRITE);

	// sequence one request and form each result word
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		do_hit    = 1'b0;
		do_clear  = 1'b0;
		do_fin    = 1'b0;
		do_rel    = 1'b0;
		do_inv    = 1'b0;
		do_syncwb = 1'b0;
		adv       = 1'b0;
		edata.code       = bbc_pkg::CODE_DONE;
		edata.slot       = 4'd0;
		edata.hit        = 1'b0;
		edata.out_device = 8'd0;
		edata.out_block  = 32'd0;
		edata.last       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (req_q.op)
					bbc_pkg::OP_READ, bbc_pkg::OP_WRITE: begin
						if (hit_q) begin
							edata.code = bbc_pkg::CODE_GRANTED;
							edata.slot = slot4(mslot_q);
							edata.hit  = 1'b1;
							if (can_emit) begin
								emit    = 1'b1;
								do_hit  = 1'b1;
								state_d = ST_IDLE;
							end
						end else if (dirty_q[vict_q]) begin
							edata.code       = bbc_pkg::CODE_WRITEBACK;
							edata.slot       = slot4(vict_q);
							edata.out_device = tdev_q[vict_q];
							edata.out_block  = tblk_q[vict_q];
							edata.last       = 1'b0;
							if (can_emit) begin
								emit     = 1'b1;
								do_clear = 1'b1;
								state_d  = ST_FILL;
							end
						end else begin
							do_clear = 1'b1;
							state_d  = ST_FILL;
						end
					end
					bbc_pkg::OP_RELEASE: begin
						edata.slot = req_q.slot_index;
						if (can_emit) begin
							emit    = 1'b1;
							do_rel  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					bbc_pkg::OP_INVAL: begin
						edata.hit  = hit_q;
						edata.slot = hit_q ? slot4(mslot_q) : 4'd0;
						if (can_emit) begin
							emit    = 1'b1;
							do_inv  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					bbc_pkg::OP_SYNC: begin
						state_d = ST_SYNC;
					end
					default: begin
						edata.code = bbc_pkg::CODE_FAILED;
						if (can_emit) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_FILL: begin
				edata.code       = bbc_pkg::CODE_FILL;
				edata.slot       = slot4(vict_q);
				edata.out_device = req_q.device;
				edata.out_block  = req_q.block_number;
				edata.last       = 1'b0;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				edata.code = (req_q.fill_status == bbc_pkg::FS_OK)
					? bbc_pkg::CODE_GRANTED : bbc_pkg::CODE_FAILED;
				edata.slot = slot4(vict_q);
				if (can_emit) begin
					emit    = 1'b1;
					do_fin  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SYNC: begin
				if ((rnk_q == RANK_END) || (cnt_q == WB_MAX)) begin
					if (can_emit) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (valid_q[sidx] && dirty_q[sidx]) begin
					edata.code       = bbc_pkg::CODE_WRITEBACK;
					edata.slot       = slot4(sidx);
					edata.out_device = tdev_q[sidx];
					edata.out_block  = tblk_q[sidx];
					edata.last       = 1'b0;
					if (can_emit) begin
						emit      = 1'b1;
						do_syncwb = 1'b1;
						adv       = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// pick the slot that moves to the head of the recency order
	always_comb begin
		mru_en   = do_hit || (do_fin && (req_q.fill_status != bbc_pkg::FS_NODEV));
		mru_slot = do_hit ? mslot_q : vict_q;
		mru_old  = rank_q[mru_slot];
	end

	// update cache state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			busy_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				tdev_q[i] <= bbc_pkg::DEV_ONES;
				tblk_q[i] <= bbc_pkg::BLK_ONES;
				rank_q[i] <= SW'(i);
			end
		end else begin
			if (mru_en) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (rank_q[i] < mru_old) begin
						rank_q[i] <= rank_q[i] + SW'(1);
					end
				end
				rank_q[mru_slot] <= '0;
			end
			if (do_hit) begin
				if (is_wr) begin
					dirty_q[mslot_q] <= 1'b1;
					busy_q[mslot_q]  <= 1'b0;
				end else begin
					busy_q[mslot_q] <= 1'b1;
				end
			end
			if (do_clear) begin
				valid_q[vict_q] <= 1'b0;
				dirty_q[vict_q] <= 1'b0;
				busy_q[vict_q]  <= 1'b0;
				tdev_q[vict_q]  <= bbc_pkg::DEV_ONES;
				tblk_q[vict_q]  <= bbc_pkg::BLK_ONES;
			end
			if (do_fin && (req_q.fill_status == bbc_pkg::FS_OK)) begin
				tdev_q[vict_q]  <= req_q.device;
				tblk_q[vict_q]  <= req_q.block_number;
				valid_q[vict_q] <= 1'b1;
				if (is_wr) begin
					dirty_q[vict_q] <= 1'b1;
				end else begin
					busy_q[vict_q] <= 1'b1;
				end
			end
			if (do_rel) begin
				for (int i = 0; i < SLOTS; i++) begin
					if ({28'd0, req_q.slot_index} == 32'(i)) begin
						busy_q[i] <= 1'b0;
					end
				end
			end
			if (do_inv && hit_q) begin
				valid_q[mslot_q] <= 1'b0;
			end
			if (do_syncwb) begin
				dirty_q[sidx] <= 1'b0;
			end
		end
	end

	// hold the request and lookup results
	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= head.entry;
		end
		if (state_q == ST_LOOK) begin
			hit_q   <= any_match;
			mslot_q <= midx;
			vict_q  <= vidx;
		end
	end

	// control registers and the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnk_q   <= '0;
			cnt_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOOK) begin
				rnk_q <= '0;
				cnt_q <= '0;
			end else if (adv) begin
				rnk_q <= rnk_q + RW'(1);
				if (do_syncwb) begin
					cnt_q <= cnt_q + bbc_pkg::CNT_W'(1);
				end
			end
			if (emit) begin
				oval_q <= 1'b1;
			end else if (rsp.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oreg_q <= edata;
		end
	end

	assign rsp.valid = oval_q;
	assign rsp.data  = oreg_q;

endmodule

FILE: tb/bbc_tb_if.sv
`timescale 1ns / 1ps
// Monitor-side view of both channels, used by the checker.
interface bbc_watch_if (
	input logic          clk,
	input logic          req_valid,
	input logic          req_ready,
	input bbc_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bbc_pkg::rsp_t rsp_data
);
	modport source (input clk, req_valid, req_ready, req_data, rsp_valid, rsp_ready, rsp_data);
	modport sink (input clk, req_valid, req_ready, req_data, rsp_valid, rsp_ready, rsp_data);
endinterface

FILE: tb/bbc_checker.sv
`timescale 1ns / 1ps
module bbc_checker
	import bbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bbc_watch_if.sink   mon,
	output int          fail_count,
	output int          pending
);

	localparam int NS = SLOTS_DEF;

	logic        slot_valid [NS];
	logic        slot_dirty [NS];
	logic        slot_busy  [NS];
	logic [7:0]  slot_dev   [NS];
	logic [31:0] slot_blk   [NS];
	logic [3:0]  slot_rank  [NS];

	rsp_t expected_words [$];

	assign pending = expected_words.size();

	function automatic rsp_t mk(code_t c, int s, logic h, logic [7:0] d,
			logic [31:0] b, logic l);
		rsp_t r;
		r.code = c; r.slot = s[3:0]; r.hit = h;
		r.out_device = d; r.out_block = b; r.last = l;
		return r;
	endfunction

	function automatic void promote(int s);
		logic [3:0] old;
		old = slot_rank[s];
		for (int i = 0; i < NS; i++)
			if (slot_rank[i] < old) slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic int lookup(logic [7:0] d, logic [31:0] b);
		int best;
		best = -1;
		for (int i = 0; i < NS; i++)
			if (slot_valid[i] && slot_dev[i] == d && slot_blk[i] == b)
				if (best < 0 || slot_rank[i] < slot_rank[best]) best = i;
		return best;
	endfunction

	function automatic int slot_at_rank(int r);
		for (int i = 0; i < NS; i++)
			if (slot_rank[i] == r) return i;
		return 0;
	endfunction

	// advance the cache state by one request and queue its words
	function automatic void predict_request(req_t q);
		int s, n;
		logic wr;
		n = 0;
		if (q.kind == KIND_READ || q.kind == KIND_WRITE) begin
			wr = (q.kind == KIND_WRITE);
			s = lookup(q.device, q.block_number);
			if (s >= 0) begin
				promote(s);
				if (wr) begin
					slot_dirty[s] = 1; slot_busy[s] = 0;
				end else begin
					slot_busy[s] = 1;
				end
				expected_words.push_back(mk(CODE_GRANTED, s, 1, 0, 0, 1));
				return;
			end
			s = slot_at_rank(NS - 1);
			if (slot_dirty[s])
				expected_words.push_back(mk(CODE_WRITEBACK, s, 0, slot_dev[s],
					slot_blk[s], 0));
			slot_valid[s] = 0; slot_dirty[s] = 0; slot_busy[s] = 0;
			slot_dev[s] = DEV_ONES; slot_blk[s] = BLK_ONES;
			expected_words.push_back(mk(CODE_FILL, s, 0, q.device, q.block_number, 0));
			if (q.fill_status == FS_OK) begin
				slot_dev[s] = q.device; slot_blk[s] = q.block_number;
				slot_valid[s] = 1;
				if (wr) slot_dirty[s] = 1;
				else slot_busy[s] = 1;
				promote(s);
				expected_words.push_back(mk(CODE_GRANTED, s, 0, 0, 0, 1));
			end else begin
				if (q.fill_status != FS_NODEV) promote(s);
				expected_words.push_back(mk(CODE_FAILED, s, 0, 0, 0, 1));
			end
		end else if (q.kind == KIND_RELEASE) begin
			if (q.slot_index < NS) slot_busy[q.slot_index] = 0;
			expected_words.push_back(mk(CODE_DONE, q.slot_index, 0, 0, 0, 1));
		end else if (q.kind == KIND_INVAL) begin
			s = lookup(q.device, q.block_number);
			if (s >= 0) begin
				slot_valid[s] = 0;
				expected_words.push_back(mk(CODE_DONE, s, 1, 0, 0, 1));
			end else begin
				expected_words.push_back(mk(CODE_DONE, 0, 0, 0, 0, 1));
			end
		end else if (q.kind == KIND_SYNC) begin
			for (int r = 0; r < NS; r++) begin
				if (n >= MAX_RESULTS - 1) break;
				s = slot_at_rank(r);
				if (slot_valid[s] && slot_dirty[s]) begin
					expected_words.push_back(mk(CODE_WRITEBACK, s, 0, slot_dev[s],
						slot_blk[s], 0));
					n++;
					slot_dirty[s] = 0;
				end
			end
			expected_words.push_back(mk(CODE_DONE, 0, 0, 0, 0, 1));
		end else begin
			expected_words.push_back(mk(CODE_FAILED, 0, 0, 0, 0, 1));
		end
	endfunction

	// compare each accepted word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		rsp_t e, a;
		if (!arst_n) begin
			fail_count <= 0;
			for (int i = 0; i < NS; i++) begin
				slot_valid[i] = 0; slot_dirty[i] = 0; slot_busy[i] = 0;
				slot_dev[i] = DEV_ONES; slot_blk[i] = BLK_ONES;
				slot_rank[i] = i[3:0];
			end
			expected_words.delete();
		end else begin
			if (mon.rsp_valid && mon.rsp_ready) begin
				a = mon.rsp_data;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %p", $time, a);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					if (a !== e) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, a);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (mon.req_valid && mon.req_ready) predict_request(mon.req_data);
		end
	end

endmodule

FILE: tb/tb_block_buffer_cache_lru.sv
`timescale 1ns / 1ps
module tb_block_buffer_cache_lru;
	import bbc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending;
	int   cycles = 0;
	logic gen_done = 0;

	bbc_req_if req ();
	bbc_rsp_if rsp ();

	block_buffer_cache_lru i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	bbc_watch_if mon (.clk(clk), .req_valid(req.valid), .req_ready(req.ready),
		.req_data(req.data), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_data(rsp.data));

	bbc_checker i_chk (.clk(clk), .arst_n(arst_n), .mon(mon),
		.fail_count(fail_count), .pending(pending));

	always #1 clk = ~clk;

	// small working set so hits, dirty evictions and syncs happen often
	function automatic req_t rand_request();
		req_t q;
		q.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		if ($urandom_range(0, 9) < 8) begin
			q.device = 8'($urandom_range(0, 3));
			q.block_number = 32'($urandom_range(0, 23));
		end else begin
			q.device = 8'($urandom);
			q.block_number = $urandom;
		end
		q.slot_index = 4'($urandom);
		q.fill_status = ($urandom_range(0, 9) < 7) ? FS_OK : 2'($urandom);
		return q;
	endfunction

	function automatic req_t mk_req(logic [2:0] k, logic [7:0] d, logic [31:0] b,
			logic [3:0] si, logic [1:0] fs);
		req_t q;
		q.kind = k; q.device = d; q.block_number = b;
		q.slot_index = si; q.fill_status = fs;
		return q;
	endfunction

	// hold the word until accepted; the caller drops valid after the burst
	task automatic send_word(req_t q);
		req.valid <= 1;
		req.data <= q;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic send_random(req_t q);
		send_word(q);
		if ($urandom_range(0, 3) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// receiver stalls in its own pattern, with calm stretches
	always @(negedge clk) begin
		if (!arst_n) rsp.ready <= 0;
		else if ((cycles / 200) % 3 == 0) rsp.ready <= 1;
		else rsp.ready <= ($urandom_range(0, 2) != 0);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		req.valid = 0;
		req.data = '0;
		rsp.ready = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: misses with each fill outcome, hits, extremes, every kind
		send_word(mk_req(KIND_READ, 8'hFF, 32'hFFFF_FFFF, 0, FS_OK));
		send_word(mk_req(KIND_WRITE, 8'h00, 32'h0, 4'hF, FS_OK));
		send_word(mk_req(KIND_WRITE, 8'h00, 32'h0, 0, FS_OK));
		send_word(mk_req(KIND_READ, 8'hFF, 32'hFFFF_FFFF, 0, FS_OK));
		send_word(mk_req(KIND_READ, 8'h12, 32'h5, 0, FS_NODEV));
		send_word(mk_req(KIND_READ, 8'h13, 32'h6, 0, 2'd2));
		send_word(mk_req(KIND_WRITE, 8'h14, 32'h7, 0, 2'd3));
		send_word(mk_req(KIND_RELEASE, 0, 0, 4'hF, FS_OK));
		send_word(mk_req(KIND_RELEASE, 8'hAA, 32'h5555_AAAA, 4'h0, FS_OK));
		send_word(mk_req(KIND_INVAL, 8'hFF, 32'hFFFF_FFFF, 0, FS_OK));
		send_word(mk_req(KIND_INVAL, 8'h77, 32'h77, 0, FS_OK));
		for (int i = 0; i < 17; i++)
			send_word(mk_req(KIND_WRITE, 8'h80, 32'h8000_0000 | i, 0, FS_OK));
		send_word(mk_req(KIND_SYNC, 0, 0, 0, FS_OK));
		send_word(mk_req(KIND_SYNC, 0, 0, 0, FS_OK));
		send_word(mk_req(3'd5, 0, 0, 0, FS_OK));
		send_word(mk_req(3'd7, 0, 0, 0, FS_OK));
		for (int i = 0; i < 300; i++) send_random(rand_request());
		req.valid <= 0;
		gen_done = 1;
	end

	initial begin
		wait (gen_done);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
